@@ rtl/olt_pkg.sv @@
// Shared types and constants of the ordered list table.
`default_nettype none

package olt_pkg;

	localparam int DEPTH_DEF = 16;
	localparam int VAL_W     = 32;
	localparam int POS_W     = 4;
	localparam int CNT_W     = 5;

	typedef enum logic [2:0] {
		REQ_FRONT  = 3'd0,
		REQ_APPEND = 3'd1,
		REQ_SEARCH = 3'd2,
		REQ_DELETE = 3'd3,
		REQ_CLEAR  = 3'd4
	} req_t;

	typedef enum logic [1:0] {
		ST_OK        = 2'd0,
		ST_NOT_FOUND = 2'd1,
		ST_FULL      = 2'd2
	} status_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_SHIFT_UP,
		S_FRONT_WR,
		S_SCAN,
		S_SHIFT_DN,
		S_RESULT
	} state_t;

endpackage

`default_nettype wire

@@ rtl/ordered_list_table.sv @@
// Top level of the ordered list table: request sequencer around the entry RAM.
//
// A bounded ordered list of signed 32-bit values held in a DEPTH-entry RAM plus
// an entry count; entry 0 is the front. Each request transfer (kind in s_tuser,
// value or key in s_tdata) yields exactly one result transfer (status, position
// of the match, count afterwards). Requests are handled one at a time. Append,
// clear, unused codes and rejected inserts skip to the result state; a front
// insert, search or delete on a non-empty list walks it one entry per cycle on
// the entry RAM's single read port, to find the key and move the entries that
// follow up or down one place. A new request is taken while an earlier result
// still waits in the output register. No clearing pass is needed after reset.
`default_nettype none

module ordered_list_table #(
	parameter int DEPTH = olt_pkg::DEPTH_DEF
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [31:0] s_tdata,  // [31:0] value
	input  wire logic [2:0]  s_tuser,  // [2:0] req_type
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic      [15:0] m_tdata   // [1:0] status, [5:2] position, [10:6] entry_count
);

	localparam int AW  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW  = $clog2(DEPTH + 1);
	localparam int XW  = (AW > olt_pkg::POS_W) ? AW : olt_pkg::POS_W;
	localparam int CXW = (CW > olt_pkg::CNT_W) ? CW : olt_pkg::CNT_W;

	olt_pkg::state_t  state_q, state_nx;
	logic [CW-1:0]    count_q;
	logic [2:0]       req_q;
	logic [31:0]      val_q;
	logic             rd_on_q;
	logic [AW-1:0]    ptr_q;
	logic             v_s1;
	logic [AW-1:0]    idx_s1;
	olt_pkg::status_t st_q;
	logic [3:0]       pos_q;
	logic             m_tvalid_q;
	logic [15:0]      m_tdata_q;

	logic             ram_we;
	logic [AW-1:0]    ram_waddr;
	logic [31:0]      ram_wdata;
	logic [31:0]      ram_rdata;

	logic             acc, full, empty, hit, at_end, rd_last, slot_free, issue;
	logic [CW-1:0]    last_cnt;
	logic [XW-1:0]    idx_x;
	logic [CXW-1:0]   cnt_x;

	olt_ram #(
		.WIDTH(olt_pkg::VAL_W),
		.DEPTH(DEPTH)
	) u_entries (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.raddr(ptr_q),
		.rdata(ram_rdata)
	);

	assign acc       = s_tvalid && s_tready;
	assign full      = count_q == CW'(DEPTH);
	assign empty     = count_q == '0;
	assign last_cnt  = count_q - 1'b1;
	assign hit       = v_s1 && (ram_rdata == val_q);
	assign at_end    = CW'(idx_s1) == last_cnt;
	assign slot_free = !m_tvalid_q || m_tready;
	assign issue     = rd_on_q;
	assign idx_x     = XW'(idx_s1);
	assign cnt_x     = CXW'(count_q);
	// last read of a sweep: front insert walks down to entry 0, others up to the tail
	assign rd_last   = (state_q == olt_pkg::S_SHIFT_UP) ? (ptr_q == '0)
	                                                    : (CW'(ptr_q) == last_cnt);

	assign m_tvalid  = m_tvalid_q;
	assign m_tdata   = m_tdata_q;

	// next state
	always_comb begin
		state_nx = state_q;
		unique case (state_q)
			olt_pkg::S_IDLE: begin
				if (acc) begin
					unique case (s_tuser)
						olt_pkg::REQ_FRONT:
							state_nx = (full || empty) ? olt_pkg::S_RESULT
							                           : olt_pkg::S_SHIFT_UP;
						olt_pkg::REQ_SEARCH, olt_pkg::REQ_DELETE:
							state_nx = empty ? olt_pkg::S_RESULT : olt_pkg::S_SCAN;
						default:
							state_nx = olt_pkg::S_RESULT;
					endcase
				end
			end
			olt_pkg::S_SHIFT_UP: begin
				if (v_s1 && idx_s1 == '0) begin
					state_nx = olt_pkg::S_FRONT_WR;
				end
			end
			olt_pkg::S_FRONT_WR: state_nx = olt_pkg::S_RESULT;
			olt_pkg::S_SCAN: begin
				priority if (hit) begin
					state_nx = (req_q == olt_pkg::REQ_DELETE && !at_end)
					           ? olt_pkg::S_SHIFT_DN : olt_pkg::S_RESULT;
				end else if (v_s1 && at_end) begin
					state_nx = olt_pkg::S_RESULT;
				end else begin
					state_nx = olt_pkg::S_SCAN;
				end
			end
			olt_pkg::S_SHIFT_DN: begin
				if (v_s1 && at_end) begin
					state_nx = olt_pkg::S_RESULT;
				end
			end
			olt_pkg::S_RESULT: begin
				if (slot_free) begin
					state_nx = olt_pkg::S_IDLE;
				end
			end
			default: state_nx = olt_pkg::S_IDLE;
		endcase
	end

	// RAM write port and input handshake
	always_comb begin
		s_tready  = state_q == olt_pkg::S_IDLE;
		ram_we    = 1'b0;
		ram_waddr = '0;
		ram_wdata = s_tdata;
		unique case (state_q)
			olt_pkg::S_IDLE: begin
				if (acc && !full) begin
					if (s_tuser == olt_pkg::REQ_APPEND) begin
						ram_we    = 1'b1;
						ram_waddr = AW'(count_q);
					end else if (s_tuser == olt_pkg::REQ_FRONT && empty) begin
						ram_we    = 1'b1;
					end
				end
			end
			olt_pkg::S_SHIFT_UP: begin
				ram_we    = v_s1;
				ram_waddr = idx_s1 + 1'b1;
				ram_wdata = ram_rdata;
			end
			olt_pkg::S_FRONT_WR: begin
				ram_we    = 1'b1;
				ram_wdata = val_q;
			end
			olt_pkg::S_SHIFT_DN: begin
				ram_we    = v_s1;
				ram_waddr = idx_s1 - 1'b1;
				ram_wdata = ram_rdata;
			end
			default: begin
				ram_we = 1'b0;
			end
		endcase
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= olt_pkg::S_IDLE;
			count_q    <= '0;
			rd_on_q    <= 1'b0;
			v_s1       <= 1'b0;
			m_tvalid_q <= 1'b0;
		end else begin
			state_q <= state_nx;
			v_s1    <= issue && !(state_q == olt_pkg::S_SCAN && hit);
			unique case (state_q)
				olt_pkg::S_IDLE: begin
					if (acc) begin
						unique case (s_tuser)
							olt_pkg::REQ_FRONT: begin
								if (!full && empty) begin
									count_q <= count_q + 1'b1;
								end
								rd_on_q <= !full && !empty;
							end
							olt_pkg::REQ_APPEND: begin
								if (!full) begin
									count_q <= count_q + 1'b1;
								end
							end
							olt_pkg::REQ_SEARCH, olt_pkg::REQ_DELETE: rd_on_q <= !empty;
							olt_pkg::REQ_CLEAR: count_q <= '0;
							default: ;
						endcase
					end
				end
				olt_pkg::S_SHIFT_UP: begin
					if (issue && rd_last) begin
						rd_on_q <= 1'b0;
					end
				end
				olt_pkg::S_FRONT_WR: count_q <= count_q + 1'b1;
				olt_pkg::S_SCAN: begin
					if (hit) begin
						// restart the sweep just behind the match for a delete
						rd_on_q <= req_q == olt_pkg::REQ_DELETE && !at_end;
						if (req_q == olt_pkg::REQ_DELETE && at_end) begin
							count_q <= count_q - 1'b1;
						end
					end else if (issue && rd_last) begin
						rd_on_q <= 1'b0;
					end
				end
				olt_pkg::S_SHIFT_DN: begin
					if (issue && rd_last) begin
						rd_on_q <= 1'b0;
					end
					if (v_s1 && at_end) begin
						count_q <= count_q - 1'b1;
					end
				end
				default: ;
			endcase
			if (state_q == olt_pkg::S_RESULT && slot_free) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		idx_s1 <= ptr_q;
		unique case (state_q)
			olt_pkg::S_IDLE: begin
				if (acc) begin
					req_q <= s_tuser;
					val_q <= s_tdata;
					pos_q <= '0;
					ptr_q <= (s_tuser == olt_pkg::REQ_FRONT) ? AW'(last_cnt) : '0;
					priority if ((s_tuser == olt_pkg::REQ_FRONT ||
					              s_tuser == olt_pkg::REQ_APPEND) && full) begin
						st_q <= olt_pkg::ST_FULL;
					end else if ((s_tuser == olt_pkg::REQ_SEARCH ||
					              s_tuser == olt_pkg::REQ_DELETE) && empty) begin
						st_q <= olt_pkg::ST_NOT_FOUND;
					end else begin
						st_q <= olt_pkg::ST_OK;
					end
				end
			end
			olt_pkg::S_SHIFT_UP: begin
				if (issue) begin
					ptr_q <= ptr_q - 1'b1;
				end
			end
			olt_pkg::S_SCAN: begin
				if (hit) begin
					pos_q <= idx_x[3:0];
					ptr_q <= idx_s1 + 1'b1;
				end else begin
					if (v_s1 && at_end) begin
						st_q <= olt_pkg::ST_NOT_FOUND;
					end
					if (issue) begin
						ptr_q <= ptr_q + 1'b1;
					end
				end
			end
			olt_pkg::S_SHIFT_DN: begin
				if (issue) begin
					ptr_q <= ptr_q + 1'b1;
				end
			end
			default: ;
		endcase
		if (state_q == olt_pkg::S_RESULT && slot_free) begin
			m_tdata_q <= {5'd0, cnt_x[4:0], pos_q, st_q};
		end
	end

	// no read left in flight once the sequencer is back to taking requests
	a_idle_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		s_tready |-> (!v_s1 && !rd_on_q))
		else $error("read sweep still active while idle");

	// count holds, moves by one, or drops to zero on clear
	a_count_step: assert property (@(posedge clk) disable iff (!arst_n)
		1'b1 |=> (count_q == $past(count_q) || count_q == $past(count_q) + 1'b1 ||
		          count_q == $past(count_q) - 1'b1 || count_q == '0))
		else $error("entry count jumped");

	// count never passes the capacity
	a_count_max: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(DEPTH))
		else $error("entry count above capacity");

	// a shift never writes the entry being read in the same cycle
	a_no_rw_clash: assert property (@(posedge clk) disable iff (!arst_n)
		(ram_we && issue) |-> (ram_waddr != ptr_q))
		else $error("write and read hit the same entry");

	// a result is loaded only from the result state
	a_result_load: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_tvalid_q) |-> $past(state_q == olt_pkg::S_RESULT))
		else $error("result presented outside the result state");

endmodule

`default_nettype wire

@@ rtl/olt_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module olt_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 16,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  wire logic             clk,
	input  wire logic             we,
	input  wire logic [AW-1:0]    waddr,
	input  wire logic [WIDTH-1:0] wdata,
	input  wire logic [AW-1:0]    raddr,
	output logic      [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

`default_nettype wire

@@ test/ordered_list_table_tb.sv @@
// Testbench of the ordered list table: random request streams checked against a shadow list.

class list_tracker;
	typedef struct {
		logic [2:0]  kind;
		logic [31:0] key;
		logic [1:0]  status;
		logic [3:0]  pos;
		logic [4:0]  count;
	} outcome_t;

	logic [31:0] slots [olt_pkg::DEPTH_DEF];
	int          held;
	int          errors;
	outcome_t    awaited [$];

	function new();
		held = 0;
		errors = 0;
	endfunction

	// Apply one accepted request to the shadow list and queue the result it must give.
	function void note_request(logic [2:0] kind, logic [31:0] key);
		outcome_t want;
		int       hit;
		want.kind = kind;
		want.key = key;
		want.status = olt_pkg::ST_OK;
		want.pos = '0;
		// first match from the front, or held when the key is absent
		hit = held;
		for (int i = held - 1; i >= 0; i--)
			if (slots[i] == key)
				hit = i;
		case (kind)
			olt_pkg::REQ_FRONT, olt_pkg::REQ_APPEND: begin
				if (held >= olt_pkg::DEPTH_DEF) begin
					want.status = olt_pkg::ST_FULL;
				end else begin
					if (kind == olt_pkg::REQ_FRONT) begin
						for (int i = held; i > 0; i--)
							slots[i] = slots[i - 1];
						slots[0] = key;
					end else begin
						slots[held] = key;
					end
					held++;
				end
			end
			olt_pkg::REQ_SEARCH: begin
				if (hit == held)
					want.status = olt_pkg::ST_NOT_FOUND;
				else
					want.pos = 4'(hit);
			end
			olt_pkg::REQ_DELETE: begin
				if (hit == held) begin
					want.status = olt_pkg::ST_NOT_FOUND;
				end else begin
					want.pos = 4'(hit);
					// close the gap behind the removed entry
					for (int i = hit; i + 1 < held; i++)
						slots[i] = slots[i + 1];
					held--;
				end
			end
			olt_pkg::REQ_CLEAR: begin
				held = 0;
			end
			default: begin
			end
		endcase
		want.count = 5'(held);
		awaited.push_back(want);
	endfunction

	task check_result(logic [15:0] word);
		outcome_t want;
		if (awaited.size() == 0) begin
			report($sformatf("result %h with no request outstanding", word));
			return;
		end
		want = awaited.pop_front();
		if (word[1:0] !== want.status)
			report($sformatf("req %0d key %h: status %0d, want %0d",
				want.kind, want.key, word[1:0], want.status));
		if (word[5:2] !== want.pos)
			report($sformatf("req %0d key %h: position %0d, want %0d",
				want.kind, want.key, word[5:2], want.pos));
		if (word[10:6] !== want.count)
			report($sformatf("req %0d key %h: entry_count %0d, want %0d",
				want.kind, want.key, word[10:6], want.count));
		if (word[15:11] !== 5'd0)
			report($sformatf("req %0d key %h: padding bits %b not zero",
				want.kind, want.key, word[15:11]));
	endtask

	task report(string what);
		errors++;
		if (errors <= 40)
			$display("mismatch: %s", what);
	endtask
endclass

module ordered_list_table_tb;
	import olt_pkg::*;

	localparam int DEPTH        = DEPTH_DEF;
	localparam int RANDOM_ITEMS = 1750;
	localparam int STALL_LIMIT  = 2000;
	localparam int HOLD_CYCLES  = 300;

	// request codes the block leaves unused
	localparam logic [2:0] REQ_SPARE_A = 3'd5;
	localparam logic [2:0] REQ_SPARE_B = 3'd6;
	localparam logic [2:0] REQ_SPARE_C = 3'd7;

	typedef enum {MIX_GROW, MIX_SHRINK, MIX_CHURN} mix_t;

	logic        clk;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [31:0] s_tdata;  // [31:0] value
	logic [2:0]  s_tuser;  // [2:0] req_type
	logic        m_tvalid;
	logic        m_tready;
	logic [15:0] m_tdata;  // [1:0] status, [5:2] position, [10:6] entry_count

	list_tracker tracker = new();
	bit          tx_quiet;
	int          results_seen;
	int          idle_cycles;

	ordered_list_table #(.DEPTH(DEPTH)) u_top (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.s_tuser(s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata)
	);

	always begin
		clk = 1'b0;
		#6;
		clk = 1'b1;
		#6;
	end

	// end the run when no transfer happens on either side for too long
	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
			idle_cycles <= 0;
		end else if (idle_cycles + 1 >= STALL_LIMIT) begin
			$display("ordered_list_table_tb: errors");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	task automatic send_request(logic [2:0] kind, logic [31:0] key);
		int gap;
		gap = tx_quiet ? 0 : $urandom_range(0, 15);
		@(negedge clk);
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser <= kind;
		s_tdata <= key;
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		tracker.note_request(kind, key);
	endtask

	// result side: random stalls, quiet stretches, and two long hold-offs
	initial begin
		int gap;
		bit rx_quiet;
		m_tready = 1'b0;
		rx_quiet = 1'b0;
		@(posedge arst_n);
		forever begin
			if (results_seen % 32 == 0)
				rx_quiet = ($urandom_range(0, 3) == 0);
			if (results_seen == 200 || results_seen == 1100)
				gap = HOLD_CYCLES;
			else
				gap = rx_quiet ? 0 : $urandom_range(0, 15);
			@(negedge clk);
			if (gap > 0) begin
				m_tready <= 1'b0;
				repeat (gap) @(negedge clk);
			end
			m_tready <= 1'b1;
			@(posedge clk);
			while (!m_tvalid)
				@(posedge clk);
			tracker.check_result(m_tdata);
			results_seen++;
		end
	end

	initial begin
		logic [2:0]  opening_kind [16];
		logic [31:0] opening_key [16];
		logic [31:0] pool [6];
		logic [2:0]  kind;
		logic [31:0] key;
		mix_t        profile;
		int          roll;
		int          inserts;
		int          deletes;

		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		s_tuser = '0;
		tx_quiet = 1'b0;
		profile = MIX_GROW;
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// empty list, extreme values, a duplicate (only the first copy is found and
		// removed), all unused codes
		opening_kind = '{REQ_CLEAR, REQ_SEARCH, REQ_DELETE, REQ_APPEND,
			REQ_FRONT, REQ_APPEND, REQ_FRONT, REQ_SEARCH,
			REQ_DELETE, REQ_SEARCH, REQ_SEARCH, REQ_SPARE_A,
			REQ_SPARE_B, REQ_SPARE_C, REQ_DELETE, REQ_SEARCH};
		opening_key = '{32'h0000_0000, 32'h0000_0005, 32'h0000_0005, 32'h8000_0000,
			32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 32'h7FFF_FFFF,
			32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h0000_0000, 32'h0000_0000,
			32'hFFFF_FFFF, 32'h0000_0000, 32'hFFFF_FFFF, 32'h8000_0000};
		foreach (opening_kind[i])
			send_request(opening_kind[i], opening_key[i]);

		for (int n = 0; n < RANDOM_ITEMS; n++) begin
			if (n % 40 == 0) begin
				profile = mix_t'($urandom_range(0, 2));
				tx_quiet = ($urandom_range(0, 3) == 0);
				foreach (pool[i])
					pool[i] = $urandom;
			end
			// grow fills the list to full, shrink drains it, churn stays in between
			inserts = (profile == MIX_GROW) ? 65 : (profile == MIX_SHRINK) ? 20 : 40;
			deletes = (profile == MIX_GROW) ? 10 : (profile == MIX_SHRINK) ? 45 : 25;
			roll = $urandom_range(0, 99);
			if (roll < inserts)
				kind = $urandom_range(0, 1) ? REQ_FRONT : REQ_APPEND;
			else if (roll < inserts + deletes)
				kind = REQ_DELETE;
			else if (roll < 97)
				kind = REQ_SEARCH;
			else if (roll == 97)
				kind = REQ_CLEAR;
			else
				kind = (roll == 98) ? REQ_SPARE_A : ($urandom_range(0, 1) ? REQ_SPARE_B : REQ_SPARE_C);

			// half the keys drawn from those held in the list, so searches and deletes hit at every position
			roll = $urandom_range(0, 9);
			if (tracker.held > 0 && roll < 5) begin
				key = tracker.slots[$urandom_range(0, tracker.held - 1)];
			end else if (roll < 8) begin
				key = pool[$urandom_range(0, 5)];
			end else if (roll == 8) begin
				key = $urandom;
			end else begin
				case ($urandom_range(0, 3))
					0: key = 32'h8000_0000;
					1: key = 32'h7FFF_FFFF;
					2: key = 32'hFFFF_FFFF;
					default: key = 32'h0000_0000;
				endcase
			end
			send_request(kind, key);
		end

		@(negedge clk);
		s_tvalid <= 1'b0;
		while (tracker.awaited.size() != 0)
			@(posedge clk);
		repeat (2 * DEPTH + 10) @(posedge clk);
		if (tracker.errors == 0)
			$display("ordered_list_table_tb: clean");
		else
			$display("ordered_list_table_tb: errors");
		$finish;
	end

endmodule

@@ files.f @@
rtl/olt_pkg.sv
rtl/olt_ram.sv
rtl/ordered_list_table.sv
test/ordered_list_table_tb.sv
